// ----- rtl/core/sfm_pkg.sv -----
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants of the sparse factor marginalizer
// Field widths, register codes, state encodings and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package sfm_pkg;

  localparam int IDX_W         = 16;
  localparam int VAL_W         = 32;
  localparam int CARD_W        = 5;
  localparam int KC_W          = 3;
  localparam int MASK_W        = 4;
  localparam int NUM_CARD_REGS = 4;
  localparam int KPTR_W        = $clog2(NUM_CARD_REGS);
  // Width of any product of cardinalities and of any reduced index.
  localparam int PW            = NUM_CARD_REGS * CARD_W;

  // Digit extraction divides four quotient bits per cycle.
  localparam int DIV_BITS      = 4;
  localparam int DIV_CYCLES    = IDX_W / DIV_BITS;
  localparam int STEP_W        = $clog2(DIV_CYCLES);

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;

  localparam int MAX_KEYS_DEF    = 4;
  localparam int MAX_CARD_DEF    = 16;
  localparam int STORE_DEPTH_DEF = 65536;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_KEY0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_KEY1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_KEY2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_KEY3    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRONTAL_MASK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MODE  = 3'd6;

  localparam logic ACT_ACCUMULATE = 1'b0;
  localparam logic ACT_READ       = 1'b1;

  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_KEY,
    F_EMIT
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_RMW
  } back_state_t;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_READ,
    OP_READ_OOR
  } op_kind_t;

  typedef struct packed {
    logic [KC_W-1:0]                          key_count;
    logic [NUM_CARD_REGS-1:0][CARD_W-1:0]     card;
    logic [MASK_W-1:0]                        frontal_mask;
    logic                                     reduce_mode;
  } cfg_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [PW-1:0]     addr;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  value;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/sfm_entry_if.sv -----
// ----------------------------------------------------------------------------
// sfm_entry_if: input channel of the marginalizer
// Valid/ready channel carrying one table entry or one read request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfm_entry_if import sfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  entry_index;
  logic [VAL_W-1:0]  entry_value;

  modport source (output valid, output action, output entry_index, output entry_value,
                  input ready);
  modport sink   (input valid, input action, input entry_index, input entry_value,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sfm_result_if.sv -----
// ----------------------------------------------------------------------------
// sfm_result_if: result channel of the marginalizer
// Valid/ready channel carrying one result entry that was read.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfm_result_if import sfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  result_index;
  logic [VAL_W-1:0]  result_value;
  logic              index_out_of_range;

  modport source (output valid, output result_index, output result_value,
                  output index_out_of_range, input ready);
  modport sink   (input valid, input result_index, input result_value,
                  input index_out_of_range, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sfm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sfm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfm_cfg_if import sfm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sfm_ram.sv -----
// ----------------------------------------------------------------------------
// sfm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sfm_front.sv -----
// ----------------------------------------------------------------------------
// sfm_front: entry intake and index reduction
// Splits the full index into digits, drops eliminated keys, checks ranges and
// hands a classified operation to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfm_front import sfm_pkg::*; #(
  parameter int MAX_KEYS    = MAX_KEYS_DEF,
  parameter int MAX_CARD    = MAX_CARD_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  sfm_entry_if.sink          entry,
  input  wire cfg_t          cfg,
  input  wire logic          clear_done,
  input  wire queue_status_t q_status,
  output logic               q_push,
  output op_t                q_op
);

  front_state_t state, state_next;

  logic [KPTR_W-1:0] k;
  logic [STEP_W-1:0] step;
  logic              action;
  logic [IDX_W-1:0]  idx;
  logic [VAL_W-1:0]  value;
  logic [IDX_W-1:0]  quo;
  logic [CARD_W-1:0] part;
  logic [PW-1:0]     full;
  logic [PW-1:0]     reduced;
  logic [PW-1:0]     red;

  logic [KC_W-1:0]   n_keys;
  logic [KPTR_W-1:0] start_k;
  logic [CARD_W-1:0] c;
  logic              kept;
  logic [IDX_W-1:0]  quo_step;
  logic [CARD_W-1:0] part_step;
  logic [CARD_W:0]   trial;
  logic              accept;
  logic              drop;
  logic              oor;

  function automatic logic [CARD_W-1:0] card_of(input logic [CARD_W-1:0] r);
    if (r == '0) begin
      return CARD_W'(1);
    end else if (32'(r) > MAX_CARD) begin
      return CARD_W'(MAX_CARD);
    end
    return r;
  endfunction

  always_comb begin
    n_keys = cfg.key_count;
    if (n_keys == '0) begin
      n_keys = KC_W'(1);
    end
    if (32'(n_keys) > MAX_KEYS) begin
      n_keys = KC_W'(MAX_KEYS);
    end
    if (32'(n_keys) > NUM_CARD_REGS) begin
      n_keys = KC_W'(NUM_CARD_REGS);
    end
    start_k = KPTR_W'(n_keys - KC_W'(1));
  end

  assign c    = card_of(cfg.card[k]);
  assign kept = !cfg.frontal_mask[k];

  // Restoring division of the running quotient by the current cardinality.
  always_comb begin
    quo_step  = quo;
    part_step = part;
    trial     = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial    = {part_step, quo_step[IDX_W-1]};
      quo_step = {quo_step[IDX_W-2:0], 1'b0};
      if (trial >= {1'b0, c}) begin
        trial       = trial - {1'b0, c};
        quo_step[0] = 1'b1;
      end
      part_step = trial[CARD_W-1:0];
    end
  end

  assign entry.ready = (state == F_IDLE) && clear_done;
  assign accept      = entry.valid && entry.ready;

  assign drop = (32'(idx) >= 32'(full)) || (32'(red) >= 32'(STORE_DEPTH));
  assign oor  = (32'(idx) >= 32'(reduced)) || (32'(idx) >= 32'(STORE_DEPTH));

  always_comb begin
    q_op.index = idx;
    q_op.value = value;
    if (action == ACT_ACCUMULATE) begin
      q_op.kind = OP_ACC;
      q_op.addr = red;
    end else begin
      q_op.kind = oor ? OP_READ_OOR : OP_READ;
      q_op.addr = PW'(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = (entry.action == ACT_ACCUMULATE) ? F_DIV : F_KEY;
        end
      end
      F_DIV: begin
        if (step == STEP_W'(DIV_CYCLES - 1)) begin
          state_next = F_KEY;
        end
      end
      F_KEY: begin
        if (k == '0) begin
          state_next = F_EMIT;
        end else begin
          state_next = (action == ACT_ACCUMULATE) ? F_DIV : F_KEY;
        end
      end
      F_EMIT: begin
        if (action == ACT_ACCUMULATE && drop) begin
          state_next = F_IDLE;
        end else if (!q_status.full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Keys are visited from the least significant digit upwards; the reduced
  // product so far is also the place value of the next kept digit.
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          k       <= start_k;
          step    <= '0;
          action  <= entry.action;
          idx     <= entry.entry_index;
          value   <= entry.entry_value;
          quo     <= entry.entry_index;
          part    <= '0;
          full    <= PW'(1);
          reduced <= PW'(1);
          red     <= '0;
        end
      end
      F_DIV: begin
        quo  <= quo_step;
        part <= part_step;
        step <= step + STEP_W'(1);
      end
      F_KEY: begin
        full <= PW'(full * PW'(c));
        if (kept) begin
          reduced <= PW'(reduced * PW'(c));
          if (action == ACT_ACCUMULATE) begin
            red <= red + PW'(reduced * PW'(part));
          end
        end
        part <= '0;
        step <= '0;
        if (k != '0) begin
          k <= k - KPTR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/sfm_queue.sv -----
// ----------------------------------------------------------------------------
// sfm_queue: operation queue between front and back
// Short FIFO of classified operations so that each side may stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module sfm_queue import sfm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire op_t     push_op,
  input  wire logic    pop,
  output op_t          head,
  output queue_status_t status
);

  op_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sfm_back.sv -----
// ----------------------------------------------------------------------------
// sfm_back: result store and read-modify-write engine
// Clears the store after reset, combines values by sum or max and returns
// read entries through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfm_back import sfm_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          reduce_mode,
  input  wire op_t           head,
  input  wire queue_status_t q_status,
  output logic               q_pop,
  output logic               clear_done,
  sfm_result_if.source       result
);

  localparam int AW = $clog2(STORE_DEPTH);

  back_state_t state, state_next;

  logic [AW-1:0]    clr;
  logic [AW-1:0]    clr_next;
  op_t              cur;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             re;
  logic [VAL_W-1:0] rdata;
  logic [VAL_W:0]   sum;
  logic [VAL_W-1:0] combined;

  logic             out_free;
  logic             load_out;
  logic [IDX_W-1:0] out_index_next;
  logic [VAL_W-1:0] out_value_next;
  logic             out_oor_next;

  sfm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (head.addr[AW-1:0]),
    .rdata (rdata)
  );

  assign sum      = {1'b0, rdata} + {1'b0, cur.value};
  assign combined = (reduce_mode == MODE_SUM) ?
                    (sum[VAL_W] ? '1 : sum[VAL_W-1:0]) :
                    ((cur.value > rdata) ? cur.value : rdata);

  assign out_free   = !result.valid || result.ready;
  assign clear_done = (state != B_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  always_comb begin
    state_next     = state;
    clr_next       = clr;
    we             = 1'b0;
    waddr          = cur.addr[AW-1:0];
    wdata          = '0;
    re             = 1'b0;
    q_pop          = 1'b0;
    load_out       = 1'b0;
    out_index_next = cur.index;
    out_value_next = rdata;
    out_oor_next   = 1'b0;
    case (state)
      B_CLEAR: begin
        we       = 1'b1;
        waddr    = clr;
        clr_next = clr + AW'(1);
        if (clr == AW'(STORE_DEPTH - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_status.empty) begin
          if (head.kind == OP_READ_OOR) begin
            if (out_free) begin
              q_pop          = 1'b1;
              load_out       = 1'b1;
              out_index_next = head.index;
              out_value_next = '0;
              out_oor_next   = 1'b1;
            end
          end else begin
            q_pop      = 1'b1;
            re         = 1'b1;
            state_next = B_RMW;
          end
        end
      end
      B_RMW: begin
        if (cur.kind == OP_ACC) begin
          we         = 1'b1;
          wdata      = combined;
          state_next = B_IDLE;
        end else if (out_free) begin
          // A read returns the stored value and leaves the entry cleared.
          we         = 1'b1;
          wdata      = '0;
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (re) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.result_index       <= out_index_next;
      result.result_value       <= out_value_next;
      result.index_out_of_range <= out_oor_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sparse_factor_marginalize_top.sv -----
// ----------------------------------------------------------------------------
// sparse_factor_marginalize_top: sparse table marginalization by sum or max
// Reduces nonzero table entries onto a result store and reads results back.
// ----------------------------------------------------------------------------
// Usage:
// The entry channel takes accumulate items (full mixed-radix index and a
// Q16.16 value) and read items (reduced index). The result channel returns one
// item per read; accumulates return nothing. The cfg channel writes the seven
// registers and is always ready; write it only while the block is idle.
// Throughput is set by the front end, which extracts one digit per key with a
// divider producing four quotient bits per cycle and takes a new item only once
// the last one has gone to the queue or been dropped. The back end spends an
// idle and a read-modify-write state on each store access and answers an
// out-of-range read from the idle state alone.
// After reset a clearing pass writes zero to every store entry, during which
// the entry channel is held not ready.
// When the receiver stalls, the result waits in the output register; the front
// end keeps taking items until its two-entry operation queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_factor_marginalize_top import sfm_pkg::*; #(
  parameter int MAX_KEYS    = MAX_KEYS_DEF,
  parameter int MAX_CARD    = MAX_CARD_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  sfm_entry_if.sink    entry,
  sfm_result_if.source result,
  sfm_cfg_if.sink      cfg
);

  cfg_t          cfg_reg;
  op_t           push_op;
  op_t           head;
  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  logic          clear_done;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.key_count    <= KC_W'(1);
      cfg_reg.card         <= {NUM_CARD_REGS{CARD_W'(2)}};
      cfg_reg.frontal_mask <= MASK_W'(1);
      cfg_reg.reduce_mode  <= MODE_SUM;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_KEY_COUNT:    cfg_reg.key_count    <= cfg.data[KC_W-1:0];
        REG_CARD_KEY0:    cfg_reg.card[0]      <= cfg.data[CARD_W-1:0];
        REG_CARD_KEY1:    cfg_reg.card[1]      <= cfg.data[CARD_W-1:0];
        REG_CARD_KEY2:    cfg_reg.card[2]      <= cfg.data[CARD_W-1:0];
        REG_CARD_KEY3:    cfg_reg.card[3]      <= cfg.data[CARD_W-1:0];
        REG_FRONTAL_MASK: cfg_reg.frontal_mask <= cfg.data[MASK_W-1:0];
        REG_REDUCE_MODE:  cfg_reg.reduce_mode  <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  sfm_front #(
    .MAX_KEYS    (MAX_KEYS),
    .MAX_CARD    (MAX_CARD),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .entry      (entry),
    .cfg        (cfg_reg),
    .clear_done (clear_done),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_op       (push_op)
  );

  sfm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head    (head),
    .status  (q_status)
  );

  sfm_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .reduce_mode (cfg_reg.reduce_mode),
    .head        (head),
    .q_status    (q_status),
    .q_pop       (q_pop),
    .clear_done  (clear_done),
    .result      (result)
  );

  // No entry may be taken while the store is still being cleared.
  a_no_entry_during_clear: assert property (@(posedge clk) disable iff (rst)
    (entry.valid && entry.ready) |-> clear_done)
    else $error("entry transfer during store clearing pass");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("operation pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("operation popped from an empty queue");

  // Nothing reaches the result channel before the clearing pass has finished.
  a_no_result_during_clear: assert property (@(posedge clk) disable iff (rst)
    !clear_done |-> !result.valid)
    else $error("result presented during store clearing pass");

endmodule

`default_nettype wire

// ----- bench/tb_sparse_factor_marginalize_top.sv -----
// ----------------------------------------------------------------------------
// tb_sparse_factor_marginalize_top: self-checking bench of the marginalizer
// Streams table entries and read requests under changing key layouts and
// reduction modes, predicts every read result with a scoreboard that keeps
// its own copy of the result store, and checks each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sparse_factor_marginalize_top import sfm_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 145;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             oor;
  } read_result_t;

  class marginal_scoreboard;
    logic [KC_W-1:0]   key_count_r;
    logic [CARD_W-1:0] card_r [NUM_CARD_REGS];
    logic [MASK_W-1:0] mask_r;
    logic              mode_r;
    logic [VAL_W-1:0]  marg_store [STORE_DEPTH_DEF];
    read_result_t      expected_reads [$];
    int failures;
    int accumulates;
    int reads;
    int oor_reads;

    function new();
      key_count_r = KC_W'(1);
      for (int k = 0; k < NUM_CARD_REGS; k++) card_r[k] = CARD_W'(2);
      mask_r = MASK_W'(1);
      mode_r = MODE_SUM;
      for (int i = 0; i < STORE_DEPTH_DEF; i++) marg_store[i] = '0;
      failures = 0;
      accumulates = 0;
      reads = 0;
      oor_reads = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_KEY_COUNT:    key_count_r = data[KC_W-1:0];
        REG_CARD_KEY0:    card_r[0] = data[CARD_W-1:0];
        REG_CARD_KEY1:    card_r[1] = data[CARD_W-1:0];
        REG_CARD_KEY2:    card_r[2] = data[CARD_W-1:0];
        REG_CARD_KEY3:    card_r[3] = data[CARD_W-1:0];
        REG_FRONTAL_MASK: mask_r = data[MASK_W-1:0];
        REG_REDUCE_MODE:  mode_r = data[0];
        default: ;
      endcase
    endfunction

    function int used_keys();
      int n;
      n = int'(key_count_r);
      if (n < 1) n = 1;
      if (n > MAX_KEYS_DEF) n = MAX_KEYS_DEF;
      return n;
    endfunction

    function int card_of(int k);
      int c;
      c = int'(card_r[k]);
      if (c < 1) c = 1;
      if (c > MAX_CARD_DEF) c = MAX_CARD_DEF;
      return c;
    endfunction

    function int full_size();
      int p;
      p = 1;
      for (int k = 0; k < used_keys(); k++) p = p * card_of(k);
      return p;
    endfunction

    function int reduced_size();
      int p;
      p = 1;
      for (int k = 0; k < used_keys(); k++)
        if (!mask_r[k]) p = p * card_of(k);
      return p;
    endfunction

    // Peels digits off from the least significant key upwards and keeps
    // only those of the keys that survive the reduction.
    function int reduce_index(int full_idx);
      int rem;
      int red;
      int place;
      int c;
      rem = full_idx;
      red = 0;
      place = 1;
      for (int k = used_keys() - 1; k >= 0; k--) begin
        c = card_of(k);
        if (!mask_r[k]) begin
          red = red + (rem % c) * place;
          place = place * c;
        end
        rem = rem / c;
      end
      return red;
    endfunction

    function bit is_ignored(logic act, logic [IDX_W-1:0] idx);
      return (act == ACT_ACCUMULATE) && (int'(idx) >= full_size());
    endfunction

    function void note_entry(logic act, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
      int red;
      logic [VAL_W:0] total;
      read_result_t exp_r;
      if (act == ACT_ACCUMULATE) begin
        if (int'(idx) >= full_size()) return;
        red = reduce_index(int'(idx));
        if (mode_r == MODE_SUM) begin
          total = {1'b0, marg_store[red]} + {1'b0, val};
          marg_store[red] = total[VAL_W] ? '1 : total[VAL_W-1:0];
        end else if (val > marg_store[red]) begin
          marg_store[red] = val;
        end
        accumulates++;
      end else begin
        exp_r.index = idx;
        if (int'(idx) >= reduced_size()) begin
          exp_r.value = '0;
          exp_r.oor = 1'b1;
          oor_reads++;
        end else begin
          exp_r.value = marg_store[idx];
          exp_r.oor = 1'b0;
          marg_store[idx] = '0;
        end
        expected_reads.insert(expected_reads.size(), exp_r);
        reads++;
      end
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val, logic oor);
      read_result_t exp_r;
      if (expected_reads.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: index %h value %h oor %b", idx, val, oor);
        return;
      end
      exp_r = expected_reads.pop_front();
      if (exp_r.index !== idx || exp_r.value !== val || exp_r.oor !== oor) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("result mismatch: expected index %h value %h oor %b, got %h %h %b",
                   exp_r.index, exp_r.value, exp_r.oor, idx, val, oor);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   settings;

  marginal_scoreboard sb;

  sfm_entry_if  entry_if ();
  sfm_result_if result_if ();
  sfm_cfg_if    cfg_if ();

  sparse_factor_marginalize_top dut (
    .clk    (clk),
    .rst    (rst),
    .entry  (entry_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sparse_factor_marginalize_top test failed");
      $finish;
    end
  end

  // Result side: check every transfer and choose ready for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.result_index, result_if.result_value,
                        result_if.index_out_of_range);
      result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Leaves valid high after the transfer so that a following item can go
  // out without a bubble.
  task automatic send_entry(input logic act, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      entry_if.valid <= 1'b0;
      @(posedge clk);
    end
    entry_if.valid       <= 1'b1;
    entry_if.action      <= act;
    entry_if.entry_index <= idx;
    entry_if.entry_value <= val;
    @(posedge clk);
    while (!entry_if.ready) @(posedge clk);
    sb.note_entry(act, idx, val);
  endtask

  // Bits above the field are random; the block must ignore them.
  task automatic write_reg_tx(input logic [CFG_IDX_W-1:0] index, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom_range(255));
    case (index)
      REG_KEY_COUNT: data[KC_W-1:0] = value[KC_W-1:0];
      REG_CARD_KEY0, REG_CARD_KEY1, REG_CARD_KEY2, REG_CARD_KEY3:
        data[CARD_W-1:0] = value[CARD_W-1:0];
      REG_FRONTAL_MASK: data[MASK_W-1:0] = value[MASK_W-1:0];
      REG_REDUCE_MODE: data[0] = value[0];
      default: ;
    endcase
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(index, data);
  endtask

  task automatic apply_setting(input int kc, input int c0, input int c1, input int c2,
                               input int c3, input int mask, input int mode);
    write_reg_tx(REG_KEY_COUNT, kc);
    write_reg_tx(REG_CARD_KEY0, c0);
    write_reg_tx(REG_CARD_KEY1, c1);
    write_reg_tx(REG_CARD_KEY2, c2);
    write_reg_tx(REG_CARD_KEY3, c3);
    write_reg_tx(REG_FRONTAL_MASK, mask);
    write_reg_tx(REG_REDUCE_MODE, mode);
    if ($urandom_range(1) == 1) write_reg_tx(REG_SPARE, 0);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Accumulates give no result, so the block may still be busy after the
  // last read has come back: allow it to drain before reconfiguring.
  task automatic wait_quiet();
    entry_if.valid <= 1'b0;
    while (sb.expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_card();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(1, 16);
    if (r < 90) return 0;
    return $urandom_range(17, 31);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return VAL_W'($urandom_range(32'h3FFFF));
    if (r < 70) return VAL_W'($urandom);
    if (r < 90) return 32'hFFFF_FFFF - VAL_W'($urandom_range(32'hFFFF));
    if (r < 95) return '0;
    return '1;
  endfunction

  task automatic random_setting();
    int kc;
    kc = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(4, 7);
    if (kc == 4 && $urandom_range(1) == 1) kc = 0;
    apply_setting(kc, pick_card(), pick_card(), pick_card(), pick_card(),
                  $urandom_range(15), $urandom_range(1));
  endtask

  // Mostly well-formed accumulates and reads within the current table shape,
  // with some indices drawn from the whole field.
  task automatic random_item(output bit counted);
    int r;
    logic act;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(99);
    if (r < 62) begin
      act = ACT_ACCUMULATE;
      idx = IDX_W'($urandom_range(sb.full_size() - 1));
    end else if (r < 70) begin
      act = ACT_ACCUMULATE;
      idx = IDX_W'($urandom);
    end else if (r < 94) begin
      act = ACT_READ;
      idx = IDX_W'($urandom_range(sb.reduced_size() - 1));
    end else begin
      act = ACT_READ;
      idx = IDX_W'($urandom);
    end
    counted = !sb.is_ignored(act, idx);
    send_entry(act, idx, pick_value());
  endtask

  initial begin
    int done;
    bit counted;
    sb = new();
    rst = 1'b1;
    settings = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    entry_if.valid = 1'b0;
    entry_if.action = ACT_ACCUMULATE;
    entry_if.entry_index = '0;
    entry_if.entry_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_KEY_COUNT;
    cfg_if.data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset layout: one key, all of it eliminated, so entries 0 and 1 land on 0 and the rest are dropped.
    send_entry(ACT_ACCUMULATE, 16'd0, 32'hFFFF_FFF0);
    send_entry(ACT_ACCUMULATE, 16'd1, 32'h0000_0020);
    send_entry(ACT_ACCUMULATE, 16'd2, 32'h0000_0001);
    send_entry(ACT_ACCUMULATE, 16'hFFFF, 32'hFFFF_FFFF);
    send_entry(ACT_READ, 16'd0, 32'h0);
    send_entry(ACT_READ, 16'd0, 32'h0);
    send_entry(ACT_READ, 16'd1, 32'h0);
    send_entry(ACT_READ, 16'hFFFF, 32'hFFFF_FFFF);
    wait_quiet();

    // Three keys of 3, 4 and 5 with key 1 eliminated; the mask bit of the
    // unused key 3 is set as well.
    apply_setting(3, 3, 4, 5, 16, 4'b1010, MODE_MAX);
    send_entry(ACT_ACCUMULATE, 16'd59, 32'h0001_0000);
    send_entry(ACT_ACCUMULATE, 16'd59, 32'h0000_8000);
    send_entry(ACT_ACCUMULATE, 16'd0, 32'hFFFF_FFFF);
    send_entry(ACT_ACCUMULATE, 16'd60, 32'h0000_0005);
    send_entry(ACT_READ, 16'd14, 32'h0);
    send_entry(ACT_READ, 16'd0, 32'h0);
    send_entry(ACT_READ, 16'd15, 32'h0);
    send_entry(ACT_READ, 16'd14, 32'h0);
    send_entry(ACT_ACCUMULATE, 16'd59, 32'h0);
    send_entry(ACT_READ, 16'd14, 32'h0);
    wait_quiet();

    // Zero key count and zero cardinality both act as one.
    apply_setting(0, 0, 0, 0, 0, 4'hF, MODE_SUM);
    send_entry(ACT_ACCUMULATE, 16'd0, 32'h0000_0001);
    send_entry(ACT_ACCUMULATE, 16'd1, 32'h0000_0001);
    send_entry(ACT_READ, 16'd0, 32'h0);
    send_entry(ACT_READ, 16'd1, 32'h0);
    wait_quiet();

    // Oversized key count and cardinalities clamp to the maximum table.
    apply_setting(7, 31, 31, 31, 31, 4'hF, MODE_MAX);
    send_entry(ACT_ACCUMULATE, 16'hFFFF, 32'h0000_1234);
    send_entry(ACT_ACCUMULATE, 16'd0, 32'h0000_5678);
    send_entry(ACT_READ, 16'd0, 32'h0);
    send_entry(ACT_READ, 16'd1, 32'h0);
    wait_quiet();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_setting(4, 16, 16, 16, 16, 4'h0, MODE_SUM);
        1: apply_setting(1, 1, 1, 1, 1, 4'h0, MODE_MAX);
        2: apply_setting(4, 16, 16, 16, 16, 4'h5, MODE_MAX);
        default: random_setting();
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      done = 0;
      while (done < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) done++;
      end
      wait_quiet();
    end

    if (sb.expected_reads.size() != 0) begin
      sb.failures++;
      $display("%0d reads never answered", sb.expected_reads.size());
    end
    $display("Covered %0d accumulates and %0d reads (%0d out of range) over %0d settings,",
             sb.accumulates, sb.reads, sb.oor_reads, settings);
    $display("in sum and max modes with idle sender and stalled receiver phases.");
    if (sb.failures == 0)
      $display("sparse_factor_marginalize_top test passed");
    else
      $display("sparse_factor_marginalize_top test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/sfm_pkg.sv
rtl/core/sfm_entry_if.sv
rtl/core/sfm_result_if.sv
rtl/core/sfm_cfg_if.sv
rtl/core/sfm_ram.sv
rtl/core/sfm_front.sv
rtl/core/sfm_queue.sv
rtl/core/sfm_back.sv
rtl/core/sparse_factor_marginalize_top.sv
bench/tb_sparse_factor_marginalize_top.sv
